>>> rtl/csvt_pkg.sv
// Package for the CSV field tokenizer: constants, codes and shared types.
// Used by csvt_parse and csv_field_tokenizer_unit; depends on nothing else.
`timescale 1ns / 1ps

package csvt_pkg;

   // Field limit and derived widths.
   localparam int MAX_FIELDS = 128;
   localparam int FIELD_W    = ($clog2(MAX_FIELDS) > 7) ? $clog2(MAX_FIELDS) : 7;
   localparam int COLUMN_W   = 7;

   // Result buffer for one transaction: at most three results occur per item.
   localparam int RES_SLOTS = 4;
   localparam int RES_IDX_W = 2;
   localparam int RES_CNT_W = 3;

   // Character codes.
   localparam logic [7:0] CH_QUOTE = 8'd34;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_CR    = 8'd13;

   // Input operation codes.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOL  = 1'b1;

   // Error codes.
   localparam logic ERR_BAD_QUOTE = 1'b0;
   localparam logic ERR_TOO_MANY  = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_DEGLITCH_EN  = 2'd0;
   localparam logic [1:0] REG_JOIN_LEN     = 2'd1;
   localparam logic [1:0] REG_JOIN_FIRST   = 2'd2;
   localparam logic [1:0] REG_JOIN_SECOND  = 2'd3;
   localparam int         CSR_ADDR_W       = 4;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_EOF  = 2'd1,
      KIND_EOR  = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_START  = 2'd0,
      MODE_UNQ    = 2'd1,
      MODE_QUOTED = 2'd2
   } mode_type;

   typedef struct packed {
      logic       deglitch_en;
      logic [1:0] join_len;
      logic [7:0] join_first;
      logic [7:0] join_second;
   } cfg_type;

   typedef struct packed {
      kind_type              kind;
      logic [7:0]            out_byte;
      logic [COLUMN_W-1:0]   column;
      logic                  error_code;
   } res_type;

   typedef struct packed {
      res_type [RES_SLOTS-1:0] entries;
      logic [RES_CNT_W-1:0]    count;
   } res_list_type;

   typedef struct packed {
      mode_type             mode;
      logic                 run_odd;
      logic [2:0]           run_cnt;
      logic                 pend_quote;
      logic                 held_cr;
      logic [FIELD_W-1:0]   fidx;
      logic                 skip;
   } state_type;

endpackage

>>> rtl/csv_field_tokenizer_unit.sv
// Top level of the CSV field tokenizer: configuration registers, parser and
// result buffer. Depends on csvt_pkg and csvt_parse.
//
//   Channel | Direction | Handshake              | Payload
//   req     | in        | req_valid / req_stall  | op, text_byte
//   rsp     | out       | rsp_valid / rsp_stall  | kind, out_byte, column, error_code, last
//   csr     | in/out    | APB psel/penable/pready| paddr[3:0], pwdata, prdata (32 bits)
//
// One input transaction is parsed in the cycle it is accepted; its results
// (zero to three) leave the result buffer one per cycle while rsp_stall is
// low. A byte with one result then sustains one transaction per cycle; a line
// end with three results holds the input until its last result leaves, set
// by the single output port. Synchronous active-high reset clears the parser
// state and empties the buffer. A new transaction is taken in the cycle the
// buffer's last result leaves, so rsp_stall reaches req_stall combinationally.
`timescale 1ns / 1ps

module csv_field_tokenizer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [7:0]                    req_text_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [7:0]                    rsp_out_byte,
   output logic [6:0]                    rsp_column,
   output logic                          rsp_error_code,
   output logic                          rsp_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [csvt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   csvt_pkg::cfg_type      cfg_ff;
   csvt_pkg::cfg_type      cfg_in;
   csvt_pkg::res_list_type hold_ff;
   csvt_pkg::res_list_type hold_in;
   csvt_pkg::res_list_type new_list;
   logic [csvt_pkg::RES_CNT_W-1:0] rd_ff;
   logic [csvt_pkg::RES_CNT_W-1:0] rd_in;
   logic [csvt_pkg::RES_CNT_W-1:0] rd_next;
   logic [1:0]             reg_idx;
   logic                   csr_wr;
   logic                   accept;
   logic                   take;
   csvt_pkg::res_type      head;

   // Configuration port: writes complete in the access phase.
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            csvt_pkg::REG_DEGLITCH_EN: cfg_in.deglitch_en = csr_pwdata[0];
            csvt_pkg::REG_JOIN_LEN:    cfg_in.join_len    = csr_pwdata[1:0];
            csvt_pkg::REG_JOIN_FIRST:  cfg_in.join_first  = csr_pwdata[7:0];
            csvt_pkg::REG_JOIN_SECOND: cfg_in.join_second = csr_pwdata[7:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         csvt_pkg::REG_DEGLITCH_EN: csr_prdata = {31'd0, cfg_ff.deglitch_en};
         csvt_pkg::REG_JOIN_LEN:    csr_prdata = {30'd0, cfg_ff.join_len};
         csvt_pkg::REG_JOIN_FIRST:  csr_prdata = {24'd0, cfg_ff.join_first};
         csvt_pkg::REG_JOIN_SECOND: csr_prdata = {24'd0, cfg_ff.join_second};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deglitch_en <= 1'b0;
         cfg_ff.join_len    <= 2'd2;
         cfg_ff.join_first  <= 8'd59;
         cfg_ff.join_second <= 8'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Parser: evaluates the offered transaction against the current state.
   csvt_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .op        (req_op),
      .text_byte (req_text_byte),
      .cfg       (cfg_ff),
      .res_list  (new_list)
   );

   // Result buffer handshake: accept when the buffer empties this cycle.
   assign rsp_valid = (rd_ff != hold_ff.count);
   assign take      = rsp_valid & ~rsp_stall;
   assign rd_next   = rd_ff + csvt_pkg::RES_CNT_W'(1);
   assign req_stall = rsp_valid & ~(take & (rd_next == hold_ff.count));
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      hold_in = hold_ff;
      rd_in   = rd_ff;
      if (accept) begin
         hold_in = new_list;
         rd_in   = '0;
      end else if (take) begin
         rd_in = rd_next;
      end
   end

   // Result buffer registers; the result payload needs no reset.
   always_ff @(posedge clock) begin
      hold_ff.entries <= hold_in.entries;
      if (reset) begin
         hold_ff.count <= '0;
         rd_ff         <= '0;
      end else begin
         hold_ff.count <= hold_in.count;
         rd_ff         <= rd_in;
      end
   end

   // Output selection from the buffer head.
   assign head           = hold_ff.entries[rd_ff[csvt_pkg::RES_IDX_W-1:0]];
   assign rsp_kind       = head.kind;
   assign rsp_out_byte   = head.out_byte;
   assign rsp_column     = head.column;
   assign rsp_error_code = head.error_code;
   assign rsp_last       = (rd_next == hold_ff.count);

endmodule

>>> rtl/csvt_parse.sv
// Parser state and the single-pass logic that turns one input transaction
// into its list of results. Depends on csvt_pkg.
`timescale 1ns / 1ps

module csvt_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   op,
   input  logic [7:0]             text_byte,
   input  csvt_pkg::cfg_type      cfg,
   output csvt_pkg::res_list_type res_list
);

   typedef struct packed {
      csvt_pkg::state_type    st;
      csvt_pkg::res_list_type rl;
   } ctx_type;

   csvt_pkg::state_type state_ff;
   csvt_pkg::state_type state_in;

   // Append one result, tagged with the current column.
   function automatic ctx_type push(ctx_type c, csvt_pkg::kind_type kind,
                                    logic [7:0] b, logic err);
      ctx_type r;
      r = c;
      if (r.rl.count < csvt_pkg::RES_CNT_W'(csvt_pkg::RES_SLOTS)) begin
         r.rl.entries[r.rl.count[csvt_pkg::RES_IDX_W-1:0]].kind       = kind;
         r.rl.entries[r.rl.count[csvt_pkg::RES_IDX_W-1:0]].out_byte   = b;
         r.rl.entries[r.rl.count[csvt_pkg::RES_IDX_W-1:0]].column     =
            r.st.fidx[csvt_pkg::COLUMN_W-1:0];
         r.rl.entries[r.rl.count[csvt_pkg::RES_IDX_W-1:0]].error_code = err;
         r.rl.count = r.rl.count + csvt_pkg::RES_CNT_W'(1);
      end
      return r;
   endfunction

   function automatic ctx_type clear_run(ctx_type c);
      ctx_type r;
      r = c;
      r.st.run_odd    = 1'b0;
      r.st.run_cnt    = 3'd0;
      r.st.pend_quote = 1'b0;
      return r;
   endfunction

   // Release a held literal quote.
   function automatic ctx_type flush_pending(ctx_type c);
      ctx_type r;
      r = c;
      if (r.st.pend_quote) begin
         r = push(r, csvt_pkg::KIND_BYTE, csvt_pkg::CH_QUOTE, 1'b0);
      end
      r.st.pend_quote = 1'b0;
      return r;
   endfunction

   function automatic ctx_type enter_skip(ctx_type c);
      ctx_type r;
      r = c;
      r.st.skip    = 1'b1;
      r.st.mode    = csvt_pkg::MODE_START;
      r.st.held_cr = 1'b0;
      r = clear_run(r);
      return r;
   endfunction

   // A comma closes the field; on the last allowed field it also raises an error.
   function automatic ctx_type end_field_comma(ctx_type c);
      ctx_type r;
      r = push(c, csvt_pkg::KIND_EOF, 8'd0, 1'b0);
      if (r.st.fidx == csvt_pkg::FIELD_W'(csvt_pkg::MAX_FIELDS - 1)) begin
         r = push(r, csvt_pkg::KIND_ERR, 8'd0, csvt_pkg::ERR_TOO_MANY);
         r = enter_skip(r);
      end else begin
         r.st.fidx = r.st.fidx + csvt_pkg::FIELD_W'(1);
         r.st.mode = csvt_pkg::MODE_START;
         r = clear_run(r);
      end
      return r;
   endfunction

   function automatic ctx_type end_record(ctx_type c);
      ctx_type r;
      r = push(c, csvt_pkg::KIND_EOF, 8'd0, 1'b0);
      r = push(r, csvt_pkg::KIND_EOR, 8'd0, 1'b0);
      r.st.fidx = '0;
      r.st.mode = csvt_pkg::MODE_START;
      r = clear_run(r);
      return r;
   endfunction

   // One byte inside a quoted field, with quote-run tracking.
   function automatic ctx_type quoted_byte(ctx_type c, logic [7:0] b, logic deg);
      ctx_type r;
      r = c;
      if (b == csvt_pkg::CH_QUOTE) begin
         r.st.run_cnt = (r.st.run_cnt < 3'd4) ? r.st.run_cnt + 3'd1 : 3'd4;
         r.st.run_odd = ~r.st.run_odd;
         if (!r.st.run_odd) begin
            r = flush_pending(r);
            if (deg && r.st.run_cnt >= 3'd4) begin
               r.st.pend_quote = 1'b1;
            end else begin
               r = push(r, csvt_pkg::KIND_BYTE, csvt_pkg::CH_QUOTE, 1'b0);
            end
         end
      end else if (r.st.run_odd) begin
         r = flush_pending(r);
         r = clear_run(r);
         if (b == csvt_pkg::CH_COMMA) begin
            r = end_field_comma(r);
         end else begin
            r = push(r, csvt_pkg::KIND_ERR, 8'd0, csvt_pkg::ERR_BAD_QUOTE);
            r = enter_skip(r);
         end
      end else if (deg && r.st.run_cnt >= 3'd4 && b == csvt_pkg::CH_COMMA) begin
         // Deglitch case: the held literal is dropped.
         r = clear_run(r);
         r = end_field_comma(r);
      end else begin
         r = flush_pending(r);
         r = clear_run(r);
         r = push(r, csvt_pkg::KIND_BYTE, b, 1'b0);
      end
      return r;
   endfunction

   function automatic ctx_type process_byte(ctx_type c, logic [7:0] b, logic deg);
      ctx_type r;
      r = c;
      if (r.st.skip) begin
         r = c;
      end else if (r.st.mode == csvt_pkg::MODE_START) begin
         if (b == csvt_pkg::CH_QUOTE) begin
            r.st.mode = csvt_pkg::MODE_QUOTED;
            r = clear_run(r);
         end else if (b == csvt_pkg::CH_COMMA) begin
            r = end_field_comma(r);
         end else begin
            r = push(r, csvt_pkg::KIND_BYTE, b, 1'b0);
            r.st.mode = csvt_pkg::MODE_UNQ;
         end
      end else if (r.st.mode == csvt_pkg::MODE_UNQ) begin
         if (b == csvt_pkg::CH_COMMA) begin
            r = end_field_comma(r);
         end else begin
            r = push(r, csvt_pkg::KIND_BYTE, b, 1'b0);
         end
      end else begin
         r = quoted_byte(r, b, deg);
      end
      return r;
   endfunction

   // Line end: end a discarded line, close the record, or join lines inside a quoted field.
   function automatic ctx_type process_eol(ctx_type c, csvt_pkg::cfg_type k);
      ctx_type r;
      r = c;
      r.st.held_cr = 1'b0;
      if (r.st.skip) begin
         r.st.skip = 1'b0;
         r.st.fidx = '0;
         r.st.mode = csvt_pkg::MODE_START;
         r = clear_run(r);
      end else if (r.st.mode != csvt_pkg::MODE_QUOTED) begin
         r = end_record(r);
      end else begin
         r = flush_pending(r);
         if (r.st.run_odd) begin
            r = end_record(r);
         end else begin
            r = clear_run(r);
            if (k.join_len >= 2'd1) begin
               r = push(r, csvt_pkg::KIND_BYTE, k.join_first, 1'b0);
            end
            if (k.join_len >= 2'd2) begin
               r = push(r, csvt_pkg::KIND_BYTE, k.join_second, 1'b0);
            end
         end
      end
      return r;
   endfunction

   // Full evaluation of one transaction from the present state.
   always_comb begin
      ctx_type c;
      c.st       = state_ff;
      c.rl       = '0;
      if (op == csvt_pkg::OP_EOL) begin
         c = process_eol(c, cfg);
      end else if (c.st.skip) begin
         c.st.held_cr = 1'b0;
      end else begin
         // A held carriage return is released as an ordinary byte first.
         if (c.st.held_cr) begin
            c.st.held_cr = 1'b0;
            c = process_byte(c, csvt_pkg::CH_CR, cfg.deglitch_en);
         end
         if (!c.st.skip) begin
            if (text_byte == csvt_pkg::CH_CR) begin
               c.st.held_cr = 1'b1;
            end else begin
               c = process_byte(c, text_byte, cfg.deglitch_en);
            end
         end
      end
      state_in = c.st;
      res_list = c.rl;
   end

   // Parser state register, advanced once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode       <= csvt_pkg::MODE_START;
         state_ff.run_odd    <= 1'b0;
         state_ff.run_cnt    <= 3'd0;
         state_ff.pend_quote <= 1'b0;
         state_ff.held_cr    <= 1'b0;
         state_ff.fidx       <= '0;
         state_ff.skip       <= 1'b0;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sim/tb_csv_field_tokenizer_unit.sv
// Self-checking testbench for csv_field_tokenizer_unit: drives CSV text and line
// ends, predicts every token, and compares the tokens that come out.
// Depends on csvt_pkg and the RTL of csv_field_tokenizer_unit.
`timescale 1ns / 1ps

module tb_csv_field_tokenizer_unit;

   localparam int MAX_TOKENS_PER_ITEM = 6;
   localparam int DRAIN_CYCLES        = 8;
   localparam int RANDOM_PER_PHASE    = 25;
   localparam int TIMEOUT_NS          = 2_000_000;

   // One input transaction and one expected token.
   typedef struct packed {
      logic       op;
      logic [7:0] text;
   } text_item_type;

   typedef struct packed {
      csvt_pkg::kind_type kind;
      logic [7:0]         out_byte;
      logic [6:0]         column;
      logic               error_code;
      logic               last;
   } token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = csvt_pkg::OP_BYTE;
   logic [7:0]  req_text_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [6:0]  rsp_column;
   logic        rsp_error_code;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [csvt_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   text_item_type pending_text[$];
   token_type     expected_tokens[$];
   token_type     step_tokens[$];

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int items_queued    = 0;
   int items_accepted  = 0;
   int tokens_checked  = 0;
   int mismatches      = 0;
   int phases_run      = 0;

   // Configuration copy used by the token predictor.
   logic       cfg_deglitch    = 1'b0;
   logic [1:0] cfg_join_len    = 2'd2;
   logic [7:0] cfg_join_first  = 8'd59;
   logic [7:0] cfg_join_second = 8'd32;

   // Parser state of the token predictor.
   csvt_pkg::mode_type prs_mode    = csvt_pkg::MODE_START;
   logic               prs_odd     = 1'b0;
   int unsigned        prs_run     = 0;
   logic               prs_pend    = 1'b0;
   logic               prs_held_cr = 1'b0;
   int unsigned        prs_field   = 0;
   logic               prs_skip    = 1'b0;

   csv_field_tokenizer_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_text_byte  (req_text_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_column     (rsp_column),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d tokens still expected", expected_tokens.size());
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void emit(csvt_pkg::kind_type k, logic [7:0] b, logic err);
      token_type t;
      t.kind       = k;
      t.out_byte   = b;
      t.column     = prs_field[6:0];
      t.error_code = err;
      t.last       = 1'b0;
      if (step_tokens.size() < MAX_TOKENS_PER_ITEM)
         step_tokens.push_back(t);
   endfunction

   function automatic void clear_run();
      prs_odd  = 1'b0;
      prs_run  = 0;
      prs_pend = 1'b0;
   endfunction

   // A held literal quote goes out as a field byte.
   function automatic void release_pending();
      if (prs_pend)
         emit(csvt_pkg::KIND_BYTE, csvt_pkg::CH_QUOTE, 1'b0);
      prs_pend = 1'b0;
   endfunction

   function automatic void start_skip();
      prs_skip    = 1'b1;
      prs_mode    = csvt_pkg::MODE_START;
      prs_held_cr = 1'b0;
      clear_run();
   endfunction

   // A comma closes the field; the field after the last allowed one is an error.
   function automatic void close_by_comma();
      emit(csvt_pkg::KIND_EOF, 8'd0, 1'b0);
      if (prs_field + 1 >= csvt_pkg::MAX_FIELDS) begin
         emit(csvt_pkg::KIND_ERR, 8'd0, csvt_pkg::ERR_TOO_MANY);
         start_skip();
      end else begin
         prs_field++;
         prs_mode = csvt_pkg::MODE_START;
         clear_run();
      end
   endfunction

   function automatic void close_record();
      emit(csvt_pkg::KIND_EOF, 8'd0, 1'b0);
      emit(csvt_pkg::KIND_EOR, 8'd0, 1'b0);
      prs_field = 0;
      prs_mode  = csvt_pkg::MODE_START;
      clear_run();
   endfunction

   // A byte inside a quoted field: quote runs, closing quote and deglitch.
   function automatic void quoted_char(logic [7:0] b);
      if (b == csvt_pkg::CH_QUOTE) begin
         if (prs_run < 4)
            prs_run++;
         prs_odd = ~prs_odd;
         if (!prs_odd) begin
            release_pending();
            if (cfg_deglitch && prs_run >= 4)
               prs_pend = 1'b1;
            else
               emit(csvt_pkg::KIND_BYTE, csvt_pkg::CH_QUOTE, 1'b0);
         end
      end else if (prs_odd) begin
         release_pending();
         clear_run();
         if (b == csvt_pkg::CH_COMMA) begin
            close_by_comma();
         end else begin
            emit(csvt_pkg::KIND_ERR, 8'd0, csvt_pkg::ERR_BAD_QUOTE);
            start_skip();
         end
      end else if (cfg_deglitch && prs_run >= 4 && b == csvt_pkg::CH_COMMA) begin
         clear_run();
         close_by_comma();
      end else begin
         release_pending();
         clear_run();
         emit(csvt_pkg::KIND_BYTE, b, 1'b0);
      end
   endfunction

   function automatic void parse_char(logic [7:0] b);
      if (prs_skip)
         return;
      if (prs_mode == csvt_pkg::MODE_START) begin
         if (b == csvt_pkg::CH_QUOTE) begin
            prs_mode = csvt_pkg::MODE_QUOTED;
            clear_run();
         end else if (b == csvt_pkg::CH_COMMA) begin
            close_by_comma();
         end else begin
            emit(csvt_pkg::KIND_BYTE, b, 1'b0);
            prs_mode = csvt_pkg::MODE_UNQ;
         end
      end else if (prs_mode == csvt_pkg::MODE_UNQ) begin
         if (b == csvt_pkg::CH_COMMA)
            close_by_comma();
         else
            emit(csvt_pkg::KIND_BYTE, b, 1'b0);
      end else begin
         quoted_char(b);
      end
   endfunction

   // A line end closes the record, ends a discarded line, or joins inside quotes.
   function automatic void line_end();
      int unsigned n;
      prs_held_cr = 1'b0;
      if (prs_skip) begin
         prs_skip  = 1'b0;
         prs_field = 0;
         prs_mode  = csvt_pkg::MODE_START;
         clear_run();
      end else if (prs_mode != csvt_pkg::MODE_QUOTED) begin
         close_record();
      end else begin
         release_pending();
         if (prs_odd) begin
            close_record();
         end else begin
            clear_run();
            n = (cfg_join_len > 2'd2) ? 2 : cfg_join_len;
            if (n >= 1)
               emit(csvt_pkg::KIND_BYTE, cfg_join_first, 1'b0);
            if (n >= 2)
               emit(csvt_pkg::KIND_BYTE, cfg_join_second, 1'b0);
         end
      end
   endfunction

   // Works out the tokens of one accepted transaction and queues them.
   function automatic void tokenize_item(logic op, logic [7:0] b);
      step_tokens.delete();
      if (op == csvt_pkg::OP_EOL) begin
         line_end();
      end else if (prs_skip) begin
         prs_held_cr = 1'b0;
      end else begin
         if (prs_held_cr) begin
            prs_held_cr = 1'b0;
            parse_char(csvt_pkg::CH_CR);
         end
         if (!prs_skip) begin
            if (b == csvt_pkg::CH_CR)
               prs_held_cr = 1'b1;
            else
               parse_char(b);
         end
      end
      if (step_tokens.size() > 0)
         step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i])
         expected_tokens.push_back(step_tokens[i]);
   endfunction

   // ---------------------------------------------------------------- driver

   // Feeds queued text items; the prediction is made at the accepting edge.
   always @(posedge clock) begin : feeder
      text_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            tokenize_item(req_op, req_text_byte);
            items_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_text.pop_front();
               req_op        <= nxt.op;
               req_text_byte <= nxt.text;
               req_valid     <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Random back-pressure on the token channel.
   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: token %0d field %s mismatch, expected %0d, actual %0d",
                  $time, tokens_checked, name, want, got);
         mismatches++;
      end
   endfunction

   // Each accepted token is compared with the oldest expectation.
   always @(posedge clock) begin : token_check
      token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual kind %0d byte %0d col %0d",
                     $time, rsp_kind, rsp_out_byte, rsp_column);
            mismatches++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_kind));
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("column", 8'(want.column), 8'(rsp_column));
            check_field("error_code", 8'(want.error_code), 8'(rsp_error_code));
            check_field("last", 8'(want.last), 8'(rsp_last));
         end
         tokens_checked++;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_byte(input logic [7:0] b);
      text_item_type t;
      t.op   = csvt_pkg::OP_BYTE;
      t.text = b;
      pending_text.push_back(t);
      items_queued++;
   endtask

   // A line end carries a random, ignored byte so that its bits still toggle.
   task automatic add_eol();
      text_item_type t;
      t.op   = csvt_pkg::OP_EOL;
      t.text = 8'($urandom_range(0, 255));
      pending_text.push_back(t);
      items_queued++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == csvt_pkg::CH_QUOTE || b == csvt_pkg::CH_COMMA || b == csvt_pkg::CH_CR);
      return b;
   endfunction

   function automatic logic [7:0] noisy_byte();
      case ($urandom_range(0, 7))
         0: return csvt_pkg::CH_QUOTE;
         1: return csvt_pkg::CH_COMMA;
         2: return csvt_pkg::CH_CR;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Quoted field with doubled quotes, long quote runs, embedded line ends and CRs.
   // Now and then it ends in an even quote run instead of a closing quote.
   task automatic add_quoted_field();
      add_byte(csvt_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 5))
            0, 1: add_byte(plain_byte());
            2: repeat (2) add_byte(csvt_pkg::CH_QUOTE);
            3: repeat (2 * $urandom_range(2, 3)) add_byte(csvt_pkg::CH_QUOTE);
            4: begin
               if ($urandom_range(0, 1))
                  add_byte(csvt_pkg::CH_CR);
               add_eol();
            end
            default: begin
               add_byte(csvt_pkg::CH_CR);
               add_byte(plain_byte());
            end
         endcase
      end
      if ($urandom_range(0, 4) == 0)
         repeat (2 * $urandom_range(2, 3)) add_byte(csvt_pkg::CH_QUOTE);
      else
         add_byte(csvt_pkg::CH_QUOTE);
   endtask

   // A well-formed record with random content, sometimes with a stray byte.
   task automatic add_record();
      int nf;
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
         if (f != 0)
            add_byte(csvt_pkg::CH_COMMA);
         if ($urandom_range(0, 9) < 4)
            add_quoted_field();
         else
            repeat ($urandom_range(0, 3)) add_byte(plain_byte());
         if ($urandom_range(0, 19) == 0)
            add_byte(plain_byte());
      end
      if ($urandom_range(0, 2) == 0)
         add_byte(csvt_pkg::CH_CR);
      add_eol();
   endtask

   // One field more than allowed, so the last column and the field limit are hit.
   task automatic add_wide_record();
      for (int f = 0; f <= csvt_pkg::MAX_FIELDS; f++) begin
         if ($urandom_range(0, 3) == 0)
            add_byte(plain_byte());
         add_byte(csvt_pkg::CH_COMMA);
      end
      add_byte(plain_byte());
      add_eol();
   endtask

   task automatic fill_random(input int target);
      int start;
      start = items_queued;
      while (items_queued - start < target) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 3) == 0)
                  add_eol();
               else
                  add_byte(noisy_byte());
            end
         end else begin
            add_record();
         end
      end
   endtask

   // Waits until every queued item is taken and every token has arrived.
   task automatic wait_drained();
      while (pending_text.size() != 0 || req_valid || expected_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;
   endtask

   // ---------------------------------------------------------------- registers

   task automatic csr_cycle(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes all four registers, then reads each one back.
   task automatic apply_settings(input logic deg, input logic [1:0] jlen,
                                 input logic [7:0] jfirst, input logic [7:0] jsecond);
      logic [31:0] vals[4];
      logic [31:0] rd;
      vals[csvt_pkg::REG_DEGLITCH_EN] = {31'd0, deg};
      vals[csvt_pkg::REG_JOIN_LEN]    = {30'd0, jlen};
      vals[csvt_pkg::REG_JOIN_FIRST]  = {24'd0, jfirst};
      vals[csvt_pkg::REG_JOIN_SECOND] = {24'd0, jsecond};
      for (int i = 0; i < 4; i++)
         csr_cycle(1'b1, 2'(i), vals[i], rd);
      cfg_deglitch    = deg;
      cfg_join_len    = jlen;
      cfg_join_first  = jfirst;
      cfg_join_second = jsecond;
      for (int i = 0; i < 4; i++) begin
         csr_cycle(1'b0, 2'(i), 32'd0, rd);
         if (rd !== vals[i]) begin
            $display("%0t: register %0d readback, expected %0d, actual %0d",
                     $time, i, vals[i], rd);
            mismatches++;
         end
      end
      phases_run++;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      #1;

      // Directed lines with deglitch on and the default join characters.
      apply_settings(1'b1, 2'd2, 8'd59, 8'd32);
      // CR released by a following byte, byte extremes, trailing comma, CR before EOL.
      add_text("a\015");
      add_byte(8'hFF);
      add_byte(8'h00);
      add_text(",\015");
      add_eol();
      // Doubled quote and a line end inside quotes, then a closing quote and comma.
      add_text("\"\"\"");
      add_eol();
      add_text("\",");
      // Even run of four quotes before a comma drops the held literal.
      add_text("\"\"\"\"\",");
      // Bad character after the closing quote discards the rest of the line.
      add_text("\"k\"z");
      add_eol();
      // Leave a run of four open so the next phase sees deglitch switched off.
      add_text("\"\"\"\"\"");
      wait_drained();

      // No idling; no join characters.
      apply_settings(1'b0, 2'd0, 8'd0, 8'd255);
      add_text(",");
      add_eol();
      add_text("\"");
      add_eol();
      add_wide_record();
      fill_random(RANDOM_PER_PHASE);
      wait_drained();

      // Sender mostly idle.
      apply_settings(1'b1, 2'd1, 8'd255, 8'd0);
      send_idle_pct = 87;
      fill_random(RANDOM_PER_PHASE);
      wait_drained();

      // Receiver mostly stalling; join length 3 acts as 2.
      apply_settings(1'b0, 2'd3, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_idle_pct  = 0;
      recv_stall_pct = 87;
      fill_random(RANDOM_PER_PHASE);
      wait_drained();

      // Light idling on both sides, with one pause until all tokens are out.
      apply_settings(1'b1, 2'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_idle_pct  = 15;
      recv_stall_pct = 15;
      fill_random(RANDOM_PER_PHASE / 2);
      wait_drained();
      fill_random(RANDOM_PER_PHASE - RANDOM_PER_PHASE / 2);
      wait_drained();

      $display("Covered %0d input transactions and %0d tokens over %0d register settings,",
               items_accepted, tokens_checked, phases_run);
      $display("with quoted, deglitch, CR, error and field-limit lines under idle and stall.");
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/csvt_pkg.sv
rtl/csvt_parse.sv
rtl/csv_field_tokenizer_unit.sv
sim/tb_csv_field_tokenizer_unit.sv
